FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL; define ASSERT_OFF to drop every check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, sampled on clk, off while arst_n is low
`define X86ENC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("x86enc: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low
`define X86ENC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("x86enc: next-cycle check failed");

`else

`define X86ENC_ASSERT_IMP(lbl, ante, cons)
`define X86ENC_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

FILE: hw/rtl/x86enc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package x86enc_pkg;

	// Encoded instruction buffer
	localparam int NUM_BYTES = 12;
	localparam int IDX_W = 4;

	// Operand kinds
	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_REG  = 2'd1;
	localparam logic [1:0] KIND_MEM  = 2'd2;
	localparam logic [1:0] KIND_IMM  = 2'd3;

	// Mnemonics
	localparam logic [4:0] OP_MOV  = 5'd0;
	localparam logic [4:0] OP_TEST = 5'd7;
	localparam logic [4:0] OP_SETE = 5'd8;
	localparam logic [4:0] OP_SETL = 5'd13;
	localparam logic [4:0] OP_IMUL = 5'd14;
	localparam logic [4:0] OP_CQO  = 5'd15;
	localparam logic [4:0] OP_IDIV = 5'd16;
	localparam logic [4:0] OP_LEA  = 5'd17;
	localparam logic [4:0] OP_PUSH = 5'd18;
	localparam logic [4:0] OP_POP  = 5'd19;
	localparam logic [4:0] OP_JMP  = 5'd20;
	localparam logic [4:0] OP_JE   = 5'd21;
	localparam logic [4:0] OP_JNE  = 5'd22;
	localparam logic [4:0] OP_CALL = 5'd23;
	localparam logic [4:0] OP_RET  = 5'd24;

	// Fixed code bytes
	localparam logic [7:0] BYTE_ESC     = 8'h0F;
	localparam logic [7:0] BYTE_REX     = 8'h40;
	localparam logic [7:0] BYTE_REX_W   = 8'h48;
	localparam logic [7:0] BYTE_REX_B   = 8'h41;
	localparam logic [7:0] BYTE_SIB_RSP = 8'h24;
	localparam logic [7:0] OPC_IMUL     = 8'hAF;
	localparam logic [7:0] OPC_CQO      = 8'h99;
	localparam logic [7:0] OPC_GRP3     = 8'hF7;
	localparam logic [7:0] OPC_LEA      = 8'h8D;
	localparam logic [7:0] OPC_PUSH_REG = 8'h50;
	localparam logic [7:0] OPC_POP_REG  = 8'h58;
	localparam logic [7:0] OPC_PUSH_IMM = 8'h68;
	localparam logic [7:0] OPC_GRP5     = 8'hFF;
	localparam logic [7:0] OPC_POP_RM   = 8'h8F;
	localparam logic [7:0] OPC_JMP      = 8'hE9;
	localparam logic [7:0] OPC_JE       = 8'h84;
	localparam logic [7:0] OPC_JNE      = 8'h85;
	localparam logic [7:0] OPC_CALL     = 8'hE8;
	localparam logic [7:0] OPC_RET      = 8'hC3;

	// ModRM reg-field extensions
	localparam logic [3:0] EXT_IDIV = 4'd7;
	localparam logic [3:0] EXT_PUSH = 4'd6;
	localparam logic [3:0] EXT_POP  = 4'd0;
	localparam logic [3:0] EXT_CALL = 4'd2;

	// Arithmetic group tables, indexed by mnemonic
	localparam logic [7:0] ALU_RM [8] = '{8'h88, 8'h00, 8'h28, 8'h38,
		8'h20, 8'h30, 8'h08, 8'h84};
	localparam logic [7:0] ALU_IMM [8] = '{8'hC7, 8'h80, 8'h80, 8'h80,
		8'h80, 8'h80, 8'h80, 8'hF7};
	localparam logic [3:0] ALU_EXT [8] = '{4'd0, 4'd0, 4'd5, 4'd7,
		4'd4, 4'd6, 4'd1, 4'd0};

	// SETcc second opcode bytes, sete through setl
	localparam logic [7:0] SET_OP [6] = '{8'h94, 8'h95, 8'h9D, 8'h9E, 8'h9F, 8'h9C};

	// One abstract instruction
	typedef struct packed {
		logic [4:0]         op;
		logic [1:0]         dst_kind;
		logic [3:0]         dst_reg;
		logic [1:0]         src_kind;
		logic [3:0]         src_reg;
		logic               has_base;
		logic [3:0]         base_reg;
		logic               has_index;
		logic [3:0]         index_reg;
		logic [1:0]         scale_log;
		logic signed [31:0] displacement;
		logic signed [31:0] immediate;
	} item_t;

	// Encoded machine code, bytes[0] goes out first
	typedef struct packed {
		logic [NUM_BYTES-1:0][7:0] bytes;
		logic [IDX_W-1:0]          last_idx;
		logic                      invalid;
	} enc_t;

endpackage

`default_nettype wire

FILE: hw/rtl/x86enc_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface x86enc_in_if;
	logic               valid;
	logic               ready;
	logic [4:0]         op;
	logic [1:0]         dst_kind;
	logic [3:0]         dst_reg;
	logic [1:0]         src_kind;
	logic [3:0]         src_reg;
	logic               has_base;
	logic [3:0]         base_reg;
	logic               has_index;
	logic [3:0]         index_reg;
	logic [1:0]         scale_log;
	logic signed [31:0] displacement;
	logic signed [31:0] immediate;

	modport source (
		output valid, op, dst_kind, dst_reg, src_kind, src_reg, has_base, base_reg,
			has_index, index_reg, scale_log, displacement, immediate,
		input ready
	);

	modport sink (
		input valid, op, dst_kind, dst_reg, src_kind, src_reg, has_base, base_reg,
			has_index, index_reg, scale_log, displacement, immediate,
		output ready
	);
endinterface

`default_nettype wire

FILE: hw/rtl/x86enc_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface x86enc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] code_byte;
	logic       is_last;
	logic       invalid;

	modport source (
		output valid, code_byte, is_last, invalid,
		input ready
	);

	modport sink (
		input valid, code_byte, is_last, invalid,
		output ready
	);
endinterface

`default_nettype wire

FILE: hw/rtl/x86enc_encoder.sv
`timescale 1ns / 1ps
`default_nettype none

module x86enc_encoder import x86enc_pkg::*; (
	input  item_t item,
	output enc_t  enc
);

	logic       ok;
	logic       mem_used;
	logic       rm_form;
	logic       w;
	logic       esc_on;
	logic       rm_mem;
	logic       imm_on;
	logic       pre_on;
	logic       direct_on;
	logic [7:0] pre_val;
	logic [7:0] opc;
	logic [7:0] direct_modrm;
	logic [3:0] regf;
	logic [3:0] rm_reg;
	logic [2:0] alu_sel;
	logic [2:0] set_sel;
	logic [4:0] set_diff;

	// Memory operand bytes
	logic [2:0] rf;
	logic [2:0] low;
	logic       disp_need;
	logic [1:0] mod;
	logic [7:0] m_modrm;
	logic       sib_on;
	logic [7:0] sib;
	logic       disp_on;

	// Prefix and ModRM of the generic form
	logic [3:0] rex_bits;
	logic       rex_on;
	logic [7:0] modrm;

	logic [IDX_W-1:0] pos;

	assign mem_used = (item.dst_kind == KIND_MEM) || (item.src_kind == KIND_MEM);
	assign alu_sel  = item.op[2:0];
	assign set_diff = item.op - OP_SETE;
	assign set_sel  = set_diff[2:0];

	// Decode mnemonic and operand kinds
	always_comb begin
		ok           = 1'b1;
		rm_form      = 1'b0;
		w            = 1'b0;
		esc_on       = 1'b0;
		rm_mem       = 1'b0;
		rm_reg       = item.dst_reg;
		regf         = 4'd0;
		imm_on       = 1'b0;
		pre_on       = 1'b0;
		pre_val      = BYTE_REX;
		opc          = 8'h00;
		direct_on    = 1'b0;
		direct_modrm = 8'h00;
		if (mem_used && item.has_index && item.index_reg == 4'd4) begin
			ok = 1'b0;
		end else if (item.op <= OP_TEST) begin
			rm_form = 1'b1;
			w       = 1'b1;
			if (item.dst_kind == KIND_REG && item.src_kind == KIND_REG) begin
				opc    = ALU_RM[alu_sel] | 8'h01;
				regf   = item.src_reg;
				rm_reg = item.dst_reg;
			end else if (item.dst_kind == KIND_REG && item.src_kind == KIND_MEM &&
					item.op != OP_TEST) begin
				opc    = ALU_RM[alu_sel] | 8'h03;
				regf   = item.dst_reg;
				rm_mem = 1'b1;
			end else if (item.dst_kind == KIND_REG && item.src_kind == KIND_IMM) begin
				opc    = ALU_IMM[alu_sel] | 8'h01;
				regf   = ALU_EXT[alu_sel];
				rm_reg = item.dst_reg;
				imm_on = 1'b1;
			end else if (item.dst_kind == KIND_MEM && item.src_kind == KIND_REG) begin
				opc    = ALU_RM[alu_sel] | 8'h01;
				regf   = item.src_reg;
				rm_mem = 1'b1;
			end else if (item.dst_kind == KIND_MEM && item.src_kind == KIND_IMM) begin
				opc    = ALU_IMM[alu_sel] | 8'h01;
				regf   = ALU_EXT[alu_sel];
				rm_mem = 1'b1;
				imm_on = 1'b1;
			end else begin
				ok = 1'b0;
			end
		end else if (item.op <= OP_SETL) begin
			// SETcc: plain REX reaches the byte registers SPL and up
			if (item.dst_kind != KIND_REG || item.src_kind != KIND_NONE) begin
				ok = 1'b0;
			end else begin
				pre_on       = item.dst_reg[3] | item.dst_reg[2];
				pre_val      = BYTE_REX | {7'd0, item.dst_reg[3]};
				esc_on       = 1'b1;
				opc          = SET_OP[set_sel];
				direct_on    = 1'b1;
				direct_modrm = {5'b11000, item.dst_reg[2:0]};
			end
		end else begin
			unique case (item.op)
				OP_IMUL: begin
					if (item.dst_kind != KIND_REG ||
							(item.src_kind != KIND_REG && item.src_kind != KIND_MEM)) begin
						ok = 1'b0;
					end else begin
						rm_form = 1'b1;
						w       = 1'b1;
						esc_on  = 1'b1;
						opc     = OPC_IMUL;
						regf    = item.dst_reg;
						rm_mem  = (item.src_kind == KIND_MEM);
						rm_reg  = item.src_reg;
					end
				end
				OP_CQO: begin
					if (item.dst_kind != KIND_NONE || item.src_kind != KIND_NONE) begin
						ok = 1'b0;
					end else begin
						pre_on  = 1'b1;
						pre_val = BYTE_REX_W;
						opc     = OPC_CQO;
					end
				end
				OP_IDIV: begin
					if (item.src_kind != KIND_NONE ||
							(item.dst_kind != KIND_REG && item.dst_kind != KIND_MEM)) begin
						ok = 1'b0;
					end else begin
						rm_form = 1'b1;
						w       = 1'b1;
						opc     = OPC_GRP3;
						regf    = EXT_IDIV;
						rm_mem  = (item.dst_kind == KIND_MEM);
					end
				end
				OP_LEA: begin
					if (item.dst_kind != KIND_REG || item.src_kind != KIND_MEM) begin
						ok = 1'b0;
					end else begin
						rm_form = 1'b1;
						w       = 1'b1;
						opc     = OPC_LEA;
						regf    = item.dst_reg;
						rm_mem  = 1'b1;
					end
				end
				OP_PUSH, OP_POP: begin
					if (item.src_kind != KIND_NONE) begin
						ok = 1'b0;
					end else if (item.dst_kind == KIND_REG) begin
						pre_on  = item.dst_reg[3];
						pre_val = BYTE_REX_B;
						opc     = ((item.op == OP_PUSH) ? OPC_PUSH_REG : OPC_POP_REG) +
							{5'd0, item.dst_reg[2:0]};
					end else if (item.dst_kind == KIND_MEM) begin
						rm_form = 1'b1;
						rm_mem  = 1'b1;
						opc     = (item.op == OP_PUSH) ? OPC_GRP5 : OPC_POP_RM;
						regf    = (item.op == OP_PUSH) ? EXT_PUSH : EXT_POP;
					end else if (item.dst_kind == KIND_IMM && item.op == OP_PUSH) begin
						opc    = OPC_PUSH_IMM;
						imm_on = 1'b1;
					end else begin
						ok = 1'b0;
					end
				end
				OP_JMP, OP_JE, OP_JNE: begin
					if (item.dst_kind != KIND_IMM || item.src_kind != KIND_NONE) begin
						ok = 1'b0;
					end else begin
						imm_on = 1'b1;
						if (item.op == OP_JMP) begin
							opc = OPC_JMP;
						end else begin
							esc_on = 1'b1;
							opc    = (item.op == OP_JE) ? OPC_JE : OPC_JNE;
						end
					end
				end
				OP_CALL: begin
					if (item.src_kind != KIND_NONE) begin
						ok = 1'b0;
					end else if (item.dst_kind == KIND_REG || item.dst_kind == KIND_MEM) begin
						rm_form = 1'b1;
						opc     = OPC_GRP5;
						regf    = EXT_CALL;
						rm_mem  = (item.dst_kind == KIND_MEM);
					end else if (item.dst_kind == KIND_IMM) begin
						opc    = OPC_CALL;
						imm_on = 1'b1;
					end else begin
						ok = 1'b0;
					end
				end
				OP_RET: begin
					if (item.dst_kind != KIND_NONE || item.src_kind != KIND_NONE) begin
						ok = 1'b0;
					end else begin
						opc = OPC_RET;
					end
				end
				default: begin
					ok = 1'b0;
				end
			endcase
		end
	end

	// Build ModRM, SIB and displacement for the memory operand
	assign rf  = regf[2:0];
	assign low = item.base_reg[2:0];
	assign disp_need = (item.displacement != 32'sd0) || !item.has_base || (low == 3'd5) ||
		(item.has_index && item.index_reg == 4'd5);
	assign mod = disp_need ? 2'b10 : 2'b00;

	always_comb begin
		m_modrm = 8'h00;
		sib     = 8'h00;
		sib_on  = 1'b0;
		disp_on = 1'b1;
		if (!item.has_base) begin
			// No base: RIP-relative, or SIB with no-base field
			if (item.has_index) begin
				m_modrm = {2'b00, rf, 3'b100};
				sib     = {item.scale_log, item.index_reg[2:0], 3'b101};
				sib_on  = 1'b1;
			end else begin
				m_modrm = {2'b00, rf, 3'b101};
			end
		end else begin
			disp_on = disp_need;
			if (item.has_index) begin
				m_modrm = {mod, rf, 3'b100};
				sib     = {item.scale_log, item.index_reg[2:0], low};
				sib_on  = 1'b1;
			end else if (low == 3'd4) begin
				// RSP or R12 base needs a SIB byte
				m_modrm = {mod, rf, 3'b100};
				sib     = BYTE_SIB_RSP;
				sib_on  = 1'b1;
			end else begin
				m_modrm = {mod, rf, low};
			end
		end
	end

	// REX and ModRM of the generic register/memory form
	assign rex_bits = {w, regf[3],
		rm_mem & item.has_index & item.index_reg[3],
		rm_mem ? (item.has_base & item.base_reg[3]) : rm_reg[3]};
	assign rex_on = |rex_bits;
	assign modrm  = rm_mem ? m_modrm : {2'b11, regf[2:0], rm_reg[2:0]};

	// Pack bytes in emission order
	always_comb begin
		enc.bytes    = '0;
		enc.invalid  = !ok;
		enc.last_idx = '0;
		pos          = '0;
		if (ok) begin
			if (rm_form ? rex_on : pre_on) begin
				enc.bytes[pos] = rm_form ? {4'b0100, rex_bits} : pre_val;
				pos = pos + 4'd1;
			end
			if (esc_on) begin
				enc.bytes[pos] = BYTE_ESC;
				pos = pos + 4'd1;
			end
			enc.bytes[pos] = opc;
			pos = pos + 4'd1;
			if (rm_form) begin
				enc.bytes[pos] = modrm;
				pos = pos + 4'd1;
				if (rm_mem && sib_on) begin
					enc.bytes[pos] = sib;
					pos = pos + 4'd1;
				end
				if (rm_mem && disp_on) begin
					for (int k = 0; k < 4; k++) begin
						enc.bytes[pos] = item.displacement[8*k +: 8];
						pos = pos + 4'd1;
					end
				end
			end else if (direct_on) begin
				enc.bytes[pos] = direct_modrm;
				pos = pos + 4'd1;
			end
			if (imm_on) begin
				for (int k = 0; k < 4; k++) begin
					enc.bytes[pos] = item.immediate[8*k +: 8];
					pos = pos + 4'd1;
				end
			end
			enc.last_idx = pos - 4'd1;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/x86enc_serial.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module x86enc_serial import x86enc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   enc_valid,
	input  enc_t   enc,
	output logic   enc_take,
	x86enc_out_if.source code
);

	logic             valid_s2;
	enc_t             enc_s2;
	logic [IDX_W-1:0] idx_q;
	logic             fire;
	logic             last;

	assign fire = code.valid & code.ready;
	assign last = (idx_q == enc_s2.last_idx);

	// Load the next instruction when the buffer is empty or the last beat of this one leaves
	assign enc_take = enc_valid & (!valid_s2 | (fire & last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_q    <= '0;
		end else if (enc_take) begin
			valid_s2 <= 1'b1;
			idx_q    <= '0;
		end else if (fire) begin
			if (last) begin
				valid_s2 <= 1'b0;
			end else begin
				idx_q <= idx_q + 4'd1;
			end
		end
	end

	// Hold encoded bytes until the whole instruction is sent
	always_ff @(posedge clk) begin
		if (enc_take) begin
			enc_s2 <= enc;
		end
	end

	// Drive one byte per beat
	assign code.valid     = valid_s2;
	assign code.code_byte = enc_s2.bytes[idx_q];
	assign code.is_last   = last;
	assign code.invalid   = enc_s2.invalid;

	`X86ENC_ASSERT_IMP(a_idx_in_range, valid_s2, idx_q <= enc_s2.last_idx)
	`X86ENC_ASSERT_IMP(a_invalid_single, valid_s2 && enc_s2.invalid, enc_s2.last_idx == 4'd0)
	`X86ENC_ASSERT_NXT(a_advance, fire && !last, valid_s2 && idx_q == $past(idx_q) + 4'd1)

endmodule

`default_nettype wire

FILE: hw/rtl/x86_64_instruction_encoder_top.sv
`timescale 1ns / 1ps
`default_nettype none

// x86-64 instruction encoder. Each beat on instr is one abstract instruction;
// its machine code leaves on code one byte per beat, is_last set on the final
// byte; an operand combination that cannot be encoded gives a single beat
// with code_byte 0, is_last 1 and invalid 1. An instruction of n bytes
// (1 to 12) holds the output channel until its n bytes are sent, so the one-byte
// code channel sets the sustained rate, with no gap between instructions when
// code.ready stays high. The first byte is driven on code once its instruction
// has passed the input register, from which the whole encoding is worked out,
// and then the byte buffer that feeds the output. The next instruction is taken
// into the input register while the previous one is still being sent.
module x86_64_instruction_encoder_top import x86enc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	x86enc_in_if.sink    instr,
	x86enc_out_if.source code
);

	logic  valid_s1;
	item_t item_s1;
	enc_t  enc;
	logic  enc_take;
	logic  accept;

	assign accept      = instr.valid & instr.ready;
	assign instr.ready = !valid_s1 | enc_take;

	// Advance the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (enc_take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.op           <= instr.op;
			item_s1.dst_kind     <= instr.dst_kind;
			item_s1.dst_reg      <= instr.dst_reg;
			item_s1.src_kind     <= instr.src_kind;
			item_s1.src_reg      <= instr.src_reg;
			item_s1.has_base     <= instr.has_base;
			item_s1.base_reg     <= instr.base_reg;
			item_s1.has_index    <= instr.has_index;
			item_s1.index_reg    <= instr.index_reg;
			item_s1.scale_log    <= instr.scale_log;
			item_s1.displacement <= instr.displacement;
			item_s1.immediate    <= instr.immediate;
		end
	end

	x86enc_encoder u_encoder (
		.item (item_s1),
		.enc  (enc)
	);

	x86enc_serial u_serial (
		.clk       (clk),
		.arst_n    (arst_n),
		.enc_valid (valid_s1),
		.enc       (enc),
		.enc_take  (enc_take),
		.code      (code)
	);

endmodule

`default_nettype wire
